// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file pcse_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while out of reset.
`define PCSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PCSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pcse_pkg.sv =====
// Types, constants and byte-update functions for the page checksum engine.
// No dependencies.
package pcse_pkg;

  localparam logic [1:0]  MODE_NONE  = 2'd0;
  localparam logic [1:0]  MODE_CRC   = 2'd1;
  localparam logic [1:0]  MODE_ADLER = 2'd2;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [15:0] ADLER_INIT = 16'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [15:0] high;
    logic [15:0] low;
  } adler_t;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic adler_t adler_byte(input adler_t s, input logic [7:0] data);
    logic [16:0] a;
    logic [16:0] b;
    adler_t      r;
    a = {1'b0, s.low} + {9'd0, data};
    if (a >= ADLER_MOD) begin
      a = a - ADLER_MOD;
    end
    b = {1'b0, s.high} + a;
    if (b >= ADLER_MOD) begin
      b = b - ADLER_MOD;
    end
    r.low  = a[15:0];
    r.high = b[15:0];
    return r;
  endfunction

endpackage

// ===== sv/pcse_in_stage.sv =====
// Input register stage: captures one byte beat and holds it until the core takes it.
// Depends on pcse_pkg.
module pcse_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pcse_pkg::beat_t in_beat,
  input  logic          advance,
  output logic          beat_valid,
  output pcse_pkg::beat_t beat
);

  logic            valid_r, valid_nxt;
  pcse_pkg::beat_t beat_r;
  logic            accept;

  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    priority if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

// ===== sv/pcse_sum_core.sv =====
// Running CRC-32 and Adler-32 state with their byte updates and result select.
// Depends on pcse_pkg.
module pcse_sum_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  pcse_pkg::beat_t beat,
  input  logic [1:0]      mode,
  output logic [31:0]     result
);

  logic [31:0]      crc_r, crc_nxt;
  pcse_pkg::adler_t adler_r, adler_nxt;
  logic [31:0]      crc_base, crc_new;
  pcse_pkg::adler_t adler_base, adler_new;

  always_comb begin
    if (beat.first) begin
      crc_base        = 32'd0;
      adler_base.low  = pcse_pkg::ADLER_INIT;
      adler_base.high = 16'd0;
    end else begin
      crc_base   = crc_r;
      adler_base = adler_r;
    end
    crc_new   = pcse_pkg::crc_byte(crc_base, beat.data);
    adler_new = pcse_pkg::adler_byte(adler_base, beat.data);
  end

  // Sums restart after the last byte of a message.
  always_comb begin
    crc_nxt   = crc_r;
    adler_nxt = adler_r;
    if (take) begin
      if (beat.last) begin
        crc_nxt        = 32'd0;
        adler_nxt.low  = pcse_pkg::ADLER_INIT;
        adler_nxt.high = 16'd0;
      end else begin
        crc_nxt   = crc_new;
        adler_nxt = adler_new;
      end
    end
  end

  always_comb begin
    unique case (mode)
      pcse_pkg::MODE_CRC:   result = crc_new;
      pcse_pkg::MODE_ADLER: result = {adler_new.high, adler_new.low};
      default:              result = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= 32'd0;
      adler_r.low  <= pcse_pkg::ADLER_INIT;
      adler_r.high <= 16'd0;
    end else begin
      crc_r   <= crc_nxt;
      adler_r <= adler_nxt;
    end
  end

endmodule

// ===== sv/page_checksum_engine_unit.sv =====
// Top level of the page checksum engine: input stage, checksum core, result register.
// Depends on pcse_pkg, pcse_in_stage and pcse_sum_core.
//
// Byte-serial CRC-32 (reflected, poly 0xEDB88320, zero init, no final xor) or
// Adler-32 over a page payload. One byte beat is taken every cycle, unless
// a last beat waits on a full, stalled result register. A message's checksum
// goes into the one-deep result register as its tlast beat leaves the input
// register. The CRC xor network and Adler add/compare chain are combinational.
// in_tuser marks the first byte (restart), in_tlast the last (result).
// cfg_data selects the mode: 0 none (result 0), 1 CRC-32, 2 Adler-32,
// 3 as none; write it only while the block is idle.
module page_checksum_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] checksum
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // checksum_mode
);

  logic [1:0]      mode_r;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r;
  logic [31:0]     result;
  pcse_pkg::beat_t in_beat;
  pcse_pkg::beat_t beat;
  logic            beat_valid;
  logic            advance;
  logic            take;
  logic            out_load;

  assign cfg_ready = 1'b1;

  assign in_beat.data  = in_tdata;
  assign in_beat.first = in_tuser;
  assign in_beat.last  = in_tlast;

  // A last beat waits only while the result register is full and stalled.
  assign advance  = !beat.last || !out_valid_r || out_tready;
  assign take     = beat_valid && advance;
  assign out_load = take && beat.last;

  pcse_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_beat   (in_beat),
    .advance   (advance),
    .beat_valid(beat_valid),
    .beat      (beat)
  );

  pcse_sum_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .beat  (beat),
    .mode  (mode_r),
    .result(result)
  );

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= pcse_pkg::MODE_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/pcse_checker.sv =====
// Port-level checks for page_checksum_engine_unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  `PCSE_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  `PCSE_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata), "stalled beat changed")

  `PCSE_ASSERT(a_in_stall_cause, clk, rst_n, !in_tready |-> out_stall, "input stalled, no result waiting")

  `PCSE_ASSERT(a_out_known, clk, rst_n, out_tvalid |-> !$isunknown(out_tdata), "unknown result data")

endmodule

bind page_checksum_engine_unit pcse_checker u_pcse_checker (.*);

// ===== tb/page_checksum_engine_unit_tb.sv =====
// Testbench for page_checksum_engine_unit: streams byte messages in CRC-32, Adler-32 and
// the result-0 modes, predicts every checksum and checks each out beat in order.
// Depends on pcse_pkg and the page_checksum_engine_unit RTL.
`timescale 1ns / 100ps

module page_checksum_engine_unit_tb;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         RANDOM_BYTES = 1500;
  localparam int         CALM_BYTES   = 200;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         LONG_HOLD    = 300;

  class checksum_scoreboard;
    logic [1:0]  mode;
    logic [31:0] crc;
    logic [15:0] adler_lo;
    logic [15:0] adler_hi;
    logic [31:0] expected_sums[$];
    int          errors;
    int          bytes_seen;
    int          checked;
    int          sums_by_mode[4];

    function new();
      mode = pcse_pkg::MODE_NONE;
      errors = 0;
      bytes_seen = 0;
      checked = 0;
      foreach (sums_by_mode[i]) sums_by_mode[i] = 0;
      restart();
    endfunction

    function void restart();
      crc = 32'd0;
      adler_lo = 16'd1;
      adler_hi = 16'd0;
    endfunction

    function void note_byte(logic [7:0] d, logic f, logic l);
      logic [16:0] s;
      int k;
      bytes_seen++;
      if (f) restart();
      crc = crc ^ {24'd0, d};
      for (k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ pcse_pkg::CRC_POLY) : (crc >> 1);
      end
      s = {1'b0, adler_lo} + {9'd0, d};
      if (s >= pcse_pkg::ADLER_MOD) s = s - pcse_pkg::ADLER_MOD;
      adler_lo = s[15:0];
      s = {1'b0, adler_hi} + {1'b0, adler_lo};
      if (s >= pcse_pkg::ADLER_MOD) s = s - pcse_pkg::ADLER_MOD;
      adler_hi = s[15:0];
      if (l) begin
        case (mode)
          pcse_pkg::MODE_CRC: begin
            expected_sums.push_back(crc);
          end
          pcse_pkg::MODE_ADLER: begin
            expected_sums.push_back({adler_hi, adler_lo});
          end
          default: begin
            expected_sums.push_back(32'd0);
          end
        endcase
        sums_by_mode[mode]++;
        restart();
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected checksum beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: checksum mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;

  checksum_scoreboard sb = new();

  bit calm = 1'b0;
  int in_gap_pct = 0;
  int hold_len = 0;
  int random_count = 0;
  int long_messages = 0;
  int quiet = 0;

  page_checksum_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // beat monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d checksums outstanding", $time, sb.pending());
        $display("page_checksum_engine_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // result side backpressure
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        n = hold_len;
        hold_len = 0;
      end else if (!calm && $urandom_range(7) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_tready <= 1'b1;
        n = calm ? 1 : $urandom_range(1, 30);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    int gap;
    if (!calm && $urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= f;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_message(input bit force_long);
    int len;
    int r;
    int i;
    bit high_bias;
    logic [7:0] d;
    logic f;
    r = $urandom_range(99);
    if (force_long || r < 3) len = $urandom_range(300, 600);
    else if (r < 20) len = $urandom_range(13, 64);
    else len = $urandom_range(1, 12);
    if (len >= 300) long_messages++;
    high_bias = (len >= 300) || ($urandom_range(3) == 0);
    for (i = 0; i < len; i++) begin
      d = high_bias ? 8'($urandom_range(200, 255)) : 8'($urandom);
      // mostly well-formed; some without first mark, a few restarted midway
      f = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
      send_byte(d, f, i == len - 1);
      random_count++;
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    int phase;
    int phase_start;
    logic [1:0] m;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode gives 0
    send_byte(8'hFF, 1'b1, 1'b1);
    wait_idle();
    write_mode(pcse_pkg::MODE_CRC);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    // no first mark after a completed message
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // restart in the middle of a message
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'h44, 1'b0, 1'b1);
    wait_idle();
    write_mode(pcse_pkg::MODE_ADLER);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    // mode switch inside an open message
    wait_idle();
    write_mode(pcse_pkg::MODE_CRC);
    send_byte(8'h01, 1'b0, 1'b1);
    wait_idle();
    write_mode(MODE_UNUSED);
    send_byte(8'hC3, 1'b1, 1'b1);

    phase = 0;
    while (random_count < RANDOM_BYTES) begin
      wait_idle();
      case (phase)
        0: m = pcse_pkg::MODE_ADLER;
        1: m = pcse_pkg::MODE_CRC;
        2: m = pcse_pkg::MODE_NONE;
        3: m = MODE_UNUSED;
        default: m = 2'($urandom_range(0, 3));
      endcase
      write_mode(m);
      case ($urandom_range(2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 35;
      endcase
      if (phase == 2) hold_len = LONG_HOLD;
      if (phase == 0 || phase == 1) send_message(1'b1);
      phase_start = random_count;
      while (random_count - phase_start < 150 && random_count < RANDOM_BYTES) begin
        calm = (random_count >= RANDOM_BYTES - CALM_BYTES);
        send_message(1'b0);
      end
      phase++;
    end

    wait_idle();
    $display("%0d bytes, %0d checksums checked over %0d mode phases, %0d long messages",
             sb.bytes_seen, sb.checked, phase, long_messages);
    $display("checksums per mode: none %0d, crc %0d, adler %0d, unused %0d",
             sb.sums_by_mode[pcse_pkg::MODE_NONE], sb.sums_by_mode[pcse_pkg::MODE_CRC],
             sb.sums_by_mode[pcse_pkg::MODE_ADLER], sb.sums_by_mode[MODE_UNUSED]);
    if (sb.errors == 0) begin
      $display("page_checksum_engine_unit_tb OK");
    end else begin
      $display("page_checksum_engine_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
